/* rtl/core/magstripe_track_field_parser_assert.svh */
// ============================================================================
// magstripe track field parser assertion macros
// clocked assertion helpers used by the top-level parser rtl file
// ============================================================================
`ifndef MAGSTRIPE_TRACK_FIELD_PARSER_ASSERT_SVH
`define MAGSTRIPE_TRACK_FIELD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock outside reset
`define MSTP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// same-cycle implication outside reset
`define MSTP_ASSERT_IMPLY(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`else

`define MSTP_ASSERT_ALWAYS(lbl, expr)
`define MSTP_ASSERT_IMPLY(lbl, cond, expr)

`endif

`endif

/* rtl/core/mstp_pkg.sv */
// ============================================================================
// mstp_pkg
// shared types and constants of the magstripe track field parser
// ============================================================================
package mstp_pkg;

    // field limits
    localparam logic [4:0] MAX_PAN  = 5'd19;
    localparam logic [4:0] MAX_NAME = 5'd26;

    // separator and filler characters
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_B     = 8'h42;

    // result queue depth
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        KIND_PAN        = 2'd0,
        KIND_NAME       = 2'd1,
        KIND_COMPLETE   = 2'd2,
        KIND_INCOMPLETE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   out_char;
        logic [4:0]   position;
        logic [4:0]   pan_length;
        logic [15:0]  expiry_packed;
        logic [23:0]  service_code;
        logic         is_last;
    } t_result;

    // results produced by one item, zero to two of them
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

/* rtl/core/mstp_parser.sv */
// ============================================================================
// mstp_parser
// per-character field state and result generation for one track
// ============================================================================
module mstp_parser
    import mstp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fmt,
    input  logic        i_accept,
    input  logic [7:0]  i_char,
    input  logic        i_eot,
    output t_push       o_push
);

    typedef enum logic [2:0] {
        PH_PAN     = 3'd0,
        PH_NAME    = 3'd1,
        PH_EXPIRY  = 3'd2,
        PH_SERVICE = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [4:0]   r_pan_cnt, n_pan_cnt;
    logic [4:0]   r_name_cnt, n_name_cnt;
    logic [1:0]   r_sub, n_sub;
    logic [15:0]  r_exp, n_exp;
    logic [23:0]  r_svc, n_svc;

    logic         v0;
    logic         v1;
    logic         pan_sep;
    t_result      e0;
    t_result      e1;
    t_push        push;

    // hex nibble of an expiry character
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] nib;
        nib = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            nib = c[3:0] + 4'd9;
        end
        return nib;
    endfunction

    // separator set of the pan field follows the format register
    assign pan_sep = i_fmt ? (i_char == CH_CARET || i_char == CH_GT)
                           : (i_char == CH_D || i_char == CH_EQ || i_char == CH_GT);

    // next state and results of the current character
    always_comb begin
        n_phase    = r_phase;
        n_pan_cnt  = r_pan_cnt;
        n_name_cnt = r_name_cnt;
        n_sub      = r_sub;
        n_exp      = r_exp;
        n_svc      = r_svc;
        v0         = 1'b0;
        v1         = 1'b0;
        e0         = '0;
        e1         = '0;

        unique case (r_phase)
            PH_PAN: begin
                if (pan_sep) begin
                    n_phase = i_fmt ? PH_NAME : PH_EXPIRY;
                    n_sub   = 2'd0;
                end else if (!(i_fmt && i_char == CH_B) && r_pan_cnt < MAX_PAN) begin
                    v0          = 1'b1;
                    e0.kind     = KIND_PAN;
                    e0.out_char = i_char;
                    e0.position = r_pan_cnt;
                    n_pan_cnt   = r_pan_cnt + 5'd1;
                end
            end
            PH_NAME: begin
                if (i_char == CH_CARET || i_char == CH_GT) begin
                    n_phase = PH_EXPIRY;
                    n_sub   = 2'd0;
                end else if (r_name_cnt < MAX_NAME) begin
                    v0          = 1'b1;
                    e0.kind     = KIND_NAME;
                    e0.out_char = i_char;
                    e0.position = r_name_cnt;
                    n_name_cnt  = r_name_cnt + 5'd1;
                end
            end
            PH_EXPIRY: begin
                n_exp = {r_exp[11:0], nibble_of(i_char)};
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    n_phase = PH_SERVICE;
                end
            end
            PH_SERVICE: begin
                n_svc = {r_svc[15:0], i_char};
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd2) begin
                    n_sub            = 2'd0;
                    n_phase          = PH_DONE;
                    v0               = 1'b1;
                    e0.kind          = KIND_COMPLETE;
                    e0.pan_length    = r_pan_cnt;
                    e0.expiry_packed = r_exp;
                    e0.service_code  = n_svc;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // end of track: incomplete summary unless complete, then back to the start
        if (i_eot) begin
            if (n_phase != PH_DONE) begin
                v1               = 1'b1;
                e1.kind          = KIND_INCOMPLETE;
                e1.pan_length    = n_pan_cnt;
                e1.expiry_packed = n_exp;
                e1.service_code  = n_svc;
            end
            n_phase    = PH_PAN;
            n_pan_cnt  = '0;
            n_name_cnt = '0;
            n_sub      = '0;
            n_exp      = '0;
            n_svc      = '0;
        end
    end

    // pack the results in order and mark the last one
    always_comb begin
        push = '0;
        if (i_accept) begin
            push.num = {1'b0, v0} + {1'b0, v1};
            if (v0) begin
                push.res0         = e0;
                push.res0.is_last = !v1;
                push.res1         = e1;
                push.res1.is_last = 1'b1;
            end else begin
                push.res0         = e1;
                push.res0.is_last = 1'b1;
            end
        end
    end

    assign o_push = push;

    // field state, cleared at reset and after each track
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PAN;
            r_pan_cnt  <= '0;
            r_name_cnt <= '0;
            r_sub      <= '0;
            r_exp      <= '0;
            r_svc      <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_pan_cnt  <= n_pan_cnt;
            r_name_cnt <= n_name_cnt;
            r_sub      <= n_sub;
            r_exp      <= n_exp;
            r_svc      <= n_svc;
        end
    end

endmodule

/* rtl/core/magstripe_track_field_parser.sv */
// ============================================================================
// magstripe_track_field_parser
// splits a magnetic-stripe track into pan, name, expiry and service fields
// ============================================================================
// usage:
//   s_axis carries one track character per item in tdata[7:0]; tlast marks
//   the final character of a track. m_axis carries results: tuser holds the
//   kind (pan char, name char, record complete, record incomplete), tdata the
//   payload, and tlast flags the last result caused by one input item.
//   The apb port holds one register at address 0: bit 0 selects the track 1
//   layout. The user must write it only while the block is idle; the block
//   does not enforce this. A character is parsed in the cycle it is accepted
//   and its results sit in a four-entry result queue, so the first result
//   shows on m_axis in the cycle after acceptance. One item is taken per cycle
//   while the queue has room for two results; output drains one result per
//   cycle while the receiver is ready. When it stalls, results wait in the
//   queue and s_axis_tready drops once three or more are held. Reset clears
//   the field state, the queue and the format register (track 2 layout).
// ============================================================================
module magstripe_track_field_parser
    import mstp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] track_char
    input  logic        s_axis_tlast,   // end_of_track
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_char, [12:8] position, [17:13] pan_length,
    // [33:18] expiry_packed, [57:34] service_code, [63:58] zero
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // is_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "magstripe_track_field_parser_assert.svh"

    localparam int PW = $clog2(QDEPTH);

    logic               r_fmt;
    t_result            r_q [QDEPTH];
    logic [PW-1:0]      r_wr, r_rd;
    logic [PW:0]        r_count, n_count;
    logic               accept;
    logic               pop;
    t_push              push;
    t_result            head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_fmt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_fmt <= pwdata[0];
        end
    end

    // take an item while two result slots are free
    assign s_axis_tready = (r_count <= (PW+1)'(QDEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    mstp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fmt    (r_fmt),
        .i_accept (accept),
        .i_char   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_push   (push)
    );

    // result queue output side
    assign head          = r_q[r_rd];
    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.is_last;
    assign m_axis_tdata  = {6'd0, head.service_code, head.expiry_packed,
                            head.pan_length, head.position, head.out_char};

    assign n_count = r_count + (PW+1)'(push.num) - (PW+1)'(pop);

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(push.num);
            r_rd    <= r_rd + PW'(pop);
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push.num != 2'd0) begin
            r_q[r_wr] <= push.res0;
        end
        if (push.num == 2'd2) begin
            r_q[r_wr + PW'(1)] <= push.res1;
        end
    end

    // checks
    `MSTP_ASSERT_ALWAYS(a_queue_bound, r_count <= (PW+1)'(QDEPTH))
    `MSTP_ASSERT_IMPLY(a_second_is_incomplete, push.num == 2'd2,
                       push.res1.kind == KIND_INCOMPLETE && !push.res0.is_last)
    `MSTP_ASSERT_IMPLY(a_push_only_on_accept, push.num != 2'd0, accept)

endmodule

/* tb/sv/magstripe_track_field_parser_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// magstripe_track_field_parser_tb
// self-checking bench for the track field parser: a behavioral parser
// predicts pan, name and summary results for every accepted character, and
// a monitor compares each result item with the oldest prediction
// ============================================================================
module magstripe_track_field_parser_tb;
    import mstp_pkg::*;

    localparam logic [2:0] ADDR_TRACK_FORMAT = 3'd0;
    localparam int SETTLE_CYCLES = 4;      // pipeline slack after last result
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 150;    // long output hold-off
    localparam int MAX_REPORTS   = 100;

    typedef enum logic [2:0] {
        TRK_PAN,
        TRK_NAME,
        TRK_EXPIRY,
        TRK_SERVICE,
        TRK_DONE
    } t_trk_phase;

    // dut signals
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] track_char
    logic        s_axis_tlast  = 1'b0;   // end_of_track
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] out_char, [12:8] position, [17:13] pan_length,
    // [33:18] expiry_packed, [57:34] service_code, [63:58] zero
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;           // is_last
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // parser state as predicted
    logic        fmt_t1;
    t_trk_phase  trk_phase;
    logic [4:0]  pan_cnt;
    logic [4:0]  name_cnt;
    logic [1:0]  sub_cnt;
    logic [15:0] expiry_acc;
    logic [23:0] service_acc;

    // predicted result items, oldest first
    t_result field_results_q [$];
    t_result want;

    int err_count      = 0;
    int mismatch_shown = 0;
    int item_count     = 0;
    int track_count    = 0;
    int fmt_writes     = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    int src_idle_pct   = 0;
    int snk_idle_pct   = 0;
    int hold_left      = 0;

    magstripe_track_field_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void clear_track();
        trk_phase   = TRK_PAN;
        pan_cnt     = '0;
        name_cnt    = '0;
        sub_cnt     = '0;
        expiry_acc  = '0;
        service_acc = '0;
    endfunction

    // hex letters map to 10..15, digits and anything else keep the low nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return c[3:0] + 4'd9;
        return c[3:0];
    endfunction

    function automatic t_result char_result(input t_kind k, input logic [7:0] c,
                                            input logic [4:0] pos);
        t_result r;
        r          = '0;
        r.kind     = k;
        r.out_char = c;
        r.position = pos;
        return r;
    endfunction

    function automatic t_result summary_result(input t_kind k);
        t_result r;
        r               = '0;
        r.kind          = k;
        r.pan_length    = pan_cnt;
        r.expiry_packed = expiry_acc;
        r.service_code  = service_acc;
        return r;
    endfunction

    // advance the parser by one character and queue the items it yields
    task automatic parse_track_char(input logic [7:0] ch, input logic eot);
        t_result res [2];
        int      n;
        logic    pan_sep;
        n = 0;
        pan_sep = fmt_t1 ? (ch == CH_CARET || ch == CH_GT)
                         : (ch == CH_D || ch == CH_EQ || ch == CH_GT);
        case (trk_phase)
            TRK_PAN: begin
                if (pan_sep) begin
                    trk_phase = fmt_t1 ? TRK_NAME : TRK_EXPIRY;
                    sub_cnt   = '0;
                end else if (!(fmt_t1 && ch == CH_B) && pan_cnt < MAX_PAN) begin
                    res[n] = char_result(KIND_PAN, ch, pan_cnt);
                    n++;
                    pan_cnt++;
                end
            end
            TRK_NAME: begin
                if (ch == CH_CARET || ch == CH_GT) begin
                    trk_phase = TRK_EXPIRY;
                    sub_cnt   = '0;
                end else if (name_cnt < MAX_NAME) begin
                    res[n] = char_result(KIND_NAME, ch, name_cnt);
                    n++;
                    name_cnt++;
                end
            end
            TRK_EXPIRY: begin
                expiry_acc = {expiry_acc[11:0], hex_nibble(ch)};
                sub_cnt++;
                if (sub_cnt == 2'd0) trk_phase = TRK_SERVICE;
            end
            TRK_SERVICE: begin
                service_acc = {service_acc[15:0], ch};
                sub_cnt++;
                if (sub_cnt == 2'd3) begin
                    sub_cnt   = '0;
                    trk_phase = TRK_DONE;
                    res[n]    = summary_result(KIND_COMPLETE);
                    n++;
                end
            end
            default: ;
        endcase
        // end of track: flag a partial record, then start over
        if (eot) begin
            if (trk_phase != TRK_DONE) begin
                res[n] = summary_result(KIND_INCOMPLETE);
                n++;
            end
            clear_track();
        end
        for (int k = 0; k < n; k++) begin
            res[k].is_last = (k == n - 1);
            field_results_q.push_back(res[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // receiver readiness, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic void cmp_field(input string fname, input logic [23:0] exp_v,
                                      input logic [23:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            if (mismatch_shown < MAX_REPORTS) begin
                mismatch_shown++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, fname, exp_v, act_v);
            end
        end
    endfunction

    // compare each accepted result item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            kind_count[m_axis_tuser]++;
            if (field_results_q.size() == 0) begin
                err_count++;
                if (mismatch_shown < MAX_REPORTS) begin
                    mismatch_shown++;
                    $display("%0t: result mismatch, expected none, actual kind %0d data %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want = field_results_q.pop_front();
                cmp_field("kind", 24'(want.kind), 24'(m_axis_tuser));
                cmp_field("out_char", 24'(want.out_char), 24'(m_axis_tdata[7:0]));
                cmp_field("position", 24'(want.position), 24'(m_axis_tdata[12:8]));
                cmp_field("pan_length", 24'(want.pan_length), 24'(m_axis_tdata[17:13]));
                cmp_field("expiry_packed", 24'(want.expiry_packed),
                          24'(m_axis_tdata[33:18]));
                cmp_field("service_code", want.service_code, m_axis_tdata[57:34]);
                cmp_field("is_last", 24'(want.is_last), 24'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    task automatic send_char(input logic [7:0] ch, input logic eot);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tlast  = eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_track_char(ch, eot);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot_last && (i == s.len() - 1));
        if (eot_last) track_count++;
    endtask

    // stop offering and let every predicted item come out
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (field_results_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_track_format(input logic t1);
        wait_drained();
        apb_write(ADDR_TRACK_FORMAT, {31'd0, t1});
        fmt_t1 = t1;
        fmt_writes++;
    endtask

    // one track: mostly well-formed, some cut short, some pure noise
    task automatic send_random_track();
        logic [7:0] trk [$];
        int         style;
        int         pan_len;
        int         name_len;
        int         cut;
        style = $urandom_range(9);
        if (style == 0) begin
            repeat ($urandom_range(40, 1)) trk.push_back(8'($urandom));
        end else begin
            // track 1 format code
            if (fmt_t1 && $urandom_range(3) != 0) trk.push_back(CH_B);
            pan_len = ($urandom_range(7) == 0) ? $urandom_range(25, 20)
                                               : $urandom_range(19, 0);
            repeat (pan_len) begin
                if ($urandom_range(15) == 0)
                    trk.push_back(8'($urandom));
                else if (fmt_t1 && $urandom_range(15) == 0)
                    trk.push_back(CH_B);
                else
                    trk.push_back(8'("0" + $urandom_range(9)));
            end
            if (fmt_t1) begin
                trk.push_back($urandom_range(1) ? CH_CARET : CH_GT);
                name_len = ($urandom_range(7) == 0) ? $urandom_range(31, 27)
                                                    : $urandom_range(26, 0);
                repeat (name_len) begin
                    if ($urandom_range(7) == 0) trk.push_back(" ");
                    else trk.push_back(8'("A" + $urandom_range(25)));
                end
                trk.push_back($urandom_range(1) ? CH_CARET : CH_GT);
            end else begin
                case ($urandom_range(2))
                    0: trk.push_back(CH_D);
                    1: trk.push_back(CH_EQ);
                    default: trk.push_back(CH_GT);
                endcase
            end
            // expiry, then service code, then discretionary data
            repeat (4) begin
                case ($urandom_range(7))
                    0: trk.push_back(8'("a" + $urandom_range(5)));
                    1: trk.push_back(8'("A" + $urandom_range(5)));
                    2: trk.push_back(8'($urandom));
                    default: trk.push_back(8'("0" + $urandom_range(9)));
                endcase
            end
            repeat (3) begin
                if ($urandom_range(7) == 0) trk.push_back(8'($urandom));
                else trk.push_back(8'("0" + $urandom_range(9)));
            end
            repeat ($urandom_range(3)) trk.push_back(8'($urandom));
            if (style <= 2) begin
                cut = $urandom_range(trk.size(), 1);
                while (trk.size() > cut) void'(trk.pop_back());
            end
        end
        for (int i = 0; i < trk.size(); i++)
            send_char(trk[i], i == trk.size() - 1);
        track_count++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // track 2: byte extremes, each separator, hex nibbles, late and early ends
    task automatic test_track2_layout();
        set_track_format(1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_D, 1'b0);
        send_text("a9F0101Y", 1'b1);    // trailing char after completion ends track
        send_char(8'hFF, 1'b0);
        send_char(CH_EQ, 1'b0);
        send_text("Z", 1'b1);           // non-hex expiry char, partial record
        send_text("7", 1'b1);           // pan char plus incomplete summary
        send_char(CH_GT, 1'b1);
        track_count++;
    endtask

    // track 1: format code dropped, track 2 separators kept as pan chars
    task automatic test_track1_layout();
        set_track_format(1'b1);
        send_char(CH_B, 1'b0);
        send_char(CH_D, 1'b0);
        send_char(CH_EQ, 1'b0);
        send_char(CH_CARET, 1'b0);
        send_text("A", 1'b0);
        send_char(CH_GT, 1'b0);
        send_text("12", 1'b1);
    endtask

    // name phase keeps running after switching back to track 2
    task automatic test_format_switch_mid_track();
        send_text("Q", 1'b0);
        send_char(CH_CARET, 1'b0);
        set_track_format(1'b0);
        send_char(CH_B, 1'b0);
        send_char(CH_CARET, 1'b0);
        send_text("5", 1'b1);
    endtask

    // output held off while input keeps coming, then a full pause
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_track_format(1'b1);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        send_random_track();
        send_random_track();
        wait_drained();
        send_random_track();
        wait_drained();
    endtask

    task automatic test_random_tracks(input int src_pct, input int snk_pct, input int n_items);
        int start;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start = item_count;
        while (item_count - start < n_items) begin
            if ($urandom_range(3) == 0) set_track_format(1'($urandom_range(1)));
            send_random_track();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        fmt_t1 = 1'b0;
        clear_track();
        src_idle_pct = 16;
        snk_idle_pct = 86;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_track2_layout();
        test_track1_layout();
        test_format_switch_mid_track();
        test_backpressure();
        test_random_tracks(16, 86, 540);
        test_random_tracks(86, 16, 540);
        test_random_tracks(0, 0, 540);
        set_track_format(1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d items over %0d tracks, %0d format writes, one long output stall",
                 item_count, track_count, fmt_writes);
        $display("results seen: %0d pan, %0d name, %0d complete, %0d incomplete",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/mstp_pkg.sv
rtl/core/mstp_parser.sv
rtl/core/magstripe_track_field_parser.sv
tb/sv/magstripe_track_field_parser_tb.sv
